### rtl/core/aes_pkg.sv
// ============================================================================
// AES-128 shared package
// S-box tables, GF(2^8) helpers and round functions used by the cipher core.
// ============================================================================
package aes_pkg;

    localparam int NumRounds = 10;
    localparam int StageIdxW = 4;

    localparam logic [1:0] CfgKeyHigh = 2'd0;
    localparam logic [1:0] CfgKeyLow  = 2'd1;

    typedef logic [127:0] block_t;

    function automatic logic [7:0] sbox_fwd(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
        endcase
        return r;
    endfunction

    // The inverse S-box is a search over the forward table: every code maps
    // to the unique preimage. Synthesis folds this into a 256-entry constant.
    function automatic logic [7:0] sbox_inv(input logic [7:0] a);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 256; i++) begin
            if (sbox_fwd(8'(i)) == a) begin
                r = 8'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of the block is bits [127-8i -: 8].
    function automatic logic [7:0] get_byte(input block_t b, input int i);
        return b[127 - 8*i -: 8];
    endfunction

    function automatic block_t shift_rows_fwd(input block_t s);
        block_t t;
        for (int i = 0; i < 16; i++) begin
            t[127 - 8*i -: 8] = get_byte(s, (i + 4*(i % 4)) % 16);
        end
        return t;
    endfunction

    function automatic block_t shift_rows_inv(input block_t s);
        block_t t;
        for (int i = 0; i < 16; i++) begin
            t[127 - 8*i -: 8] = get_byte(s, (i + 16 - 4*(i % 4)) % 16);
        end
        return t;
    endfunction

    function automatic block_t sub_bytes_fwd(input block_t s);
        block_t t;
        for (int i = 0; i < 16; i++) begin
            t[127 - 8*i -: 8] = sbox_fwd(get_byte(s, i));
        end
        return t;
    endfunction

    function automatic block_t sub_bytes_inv(input block_t s);
        block_t t;
        for (int i = 0; i < 16; i++) begin
            t[127 - 8*i -: 8] = sbox_inv(get_byte(s, i));
        end
        return t;
    endfunction

    function automatic block_t mix_fwd(input block_t s);
        block_t t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c + 1);
            a2 = get_byte(s, 4*c + 2);
            a3 = get_byte(s, 4*c + 3);
            t[127 - 32*c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[119 - 32*c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[111 - 32*c -: 8]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[103 - 32*c -: 8]  = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return t;
    endfunction

    // Inverse MixColumns as a pre-multiply by {04}x^2+{05} followed by the
    // forward matrix.
    function automatic block_t mix_inv(input block_t s);
        block_t t;
        logic [7:0] a0, a1, a2, a3, u, v;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c + 1);
            a2 = get_byte(s, 4*c + 2);
            a3 = get_byte(s, 4*c + 3);
            u = xtime(xtime(a0 ^ a2));
            v = xtime(xtime(a1 ^ a3));
            t[127 - 32*c -: 8] = a0 ^ u;
            t[119 - 32*c -: 8] = a1 ^ v;
            t[111 - 32*c -: 8] = a2 ^ u;
            t[103 - 32*c -: 8] = a3 ^ v;
        end
        return mix_fwd(t);
    endfunction

    function automatic block_t next_round_key(input block_t p, input logic [7:0] rcon);
        block_t k;
        logic [31:0] t;
        t = {sbox_fwd(p[23:16]) ^ rcon, sbox_fwd(p[15:8]), sbox_fwd(p[7:0]),
             sbox_fwd(p[31:24])};
        k[127:96] = p[127:96] ^ t;
        k[95:64]  = p[95:64] ^ k[127:96];
        k[63:32]  = p[63:32] ^ k[95:64];
        k[31:0]   = p[31:0] ^ k[63:32];
        return k;
    endfunction

    function automatic logic [7:0] rcon_of(input logic [StageIdxW-1:0] r);
        logic [7:0] c;
        c = 8'h01;
        for (int i = 1; i < NumRounds; i++) begin
            if (i < int'(r)) begin
                c = xtime(c);
            end
        end
        return c;
    endfunction

endpackage

### rtl/core/aes128_block_cipher.sv
// ============================================================================
// AES-128 block cipher
// Fully unrolled encrypt/decrypt pipeline with registered key schedule.
// ============================================================================
// Pipeline: one whitening stage plus ten round stages, the first register
// loaded at the accepting edge.
// Throughput: one item per cycle; the whole pipeline stalls together when the
// output is held by the consumer, so no item is lost or repeated.
// Reset clears the key registers, the round keys and all valid bits.
// After reset or a key write, the input is held off while the round key
// registers settle.
module aes128_block_cipher
    import aes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [63:0] text_high,
    input  logic [63:0] text_low,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_high,
    output logic [63:0] out_low,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    block_t      rk [NumRounds+1];

    // Counts down the cycles the key schedule needs after reset or a key
    // write; no item is taken until it reaches zero.
    logic [StageIdxW-1:0] settle_reg;
    logic        key_ready;

    // The pipeline moves whenever the final stage is empty or being drained.
    logic        advance;
    logic        v   [NumRounds+1];
    logic        e   [NumRounds+1];
    block_t      st  [NumRounds+1];
    logic        v0_reg;
    logic        e0_reg;
    block_t      s0_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_valid) begin
            unique case (cfg_index)
                CfgKeyHigh: key_high_reg <= cfg_data;
                CfgKeyLow:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // The counter restarts on reset and on every key write, so that a new key
    // has passed through every round key register before an item is taken.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            settle_reg <= StageIdxW'(NumRounds + 1);
        end
        else if (cfg_valid && cfg_ready) begin
            settle_reg <= StageIdxW'(NumRounds + 1);
        end
        else if (settle_reg != '0) begin
            settle_reg <= settle_reg - 1'b1;
        end
    end

    assign key_ready = (settle_reg == '0);

    aes_keyexp u_keyexp (
        .clk   (clk),
        .rst_n (rst_n),
        .key   ({key_high_reg, key_low_reg}),
        .rk    (rk)
    );

    assign advance  = !v[NumRounds] || out_ready;
    assign in_ready = advance && key_ready;

    // Stage zero: initial AddRoundKey with the first (encrypt) or last
    // (decrypt) round key.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v0_reg <= 1'b0;
        end
        else if (advance) begin
            v0_reg <= in_valid && key_ready;
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            e0_reg <= kind;
            s0_reg <= {text_high, text_low} ^ (kind ? rk[0] : rk[NumRounds]);
        end
    end

    assign v[0]  = v0_reg;
    assign e[0]  = e0_reg;
    assign st[0] = s0_reg;

    for (genvar r = 1; r <= NumRounds; r++) begin : g_round
        aes_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (v[r-1]),
            .in_enc    (e[r-1]),
            .in_last   (r == NumRounds),
            .in_state  (st[r-1]),
            .key_enc   (rk[r]),
            .key_dec   (rk[NumRounds-r]),
            .out_valid (v[r]),
            .out_enc   (e[r]),
            .out_state (st[r])
        );
    end

    assign out_valid = v[NumRounds];
    assign out_high  = st[NumRounds][127:64];
    assign out_low   = st[NumRounds][63:0];

endmodule

### rtl/core/aes_keyexp.sv
// ============================================================================
// AES-128 key schedule
// Registers the eleven round keys in a chain, each from the one before it.
// ============================================================================
module aes_keyexp
    import aes_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  block_t key,
    output block_t rk [NumRounds+1]
);

    // One round key per register; each after the first is derived from the
    // previous register, so the schedule settles down the chain after a key
    // write, and the top level takes no new item until it has settled.
    block_t rk_reg [NumRounds+1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i <= NumRounds; i++) begin
                rk_reg[i] <= '0;
            end
        end
        else begin
            rk_reg[0] <= key;
            for (int i = 1; i <= NumRounds; i++) begin
                rk_reg[i] <= next_round_key(rk_reg[i-1], rcon_of(StageIdxW'(i)));
            end
        end
    end

    assign rk = rk_reg;

endmodule

### rtl/core/aes_round.sv
// ============================================================================
// AES round stage
// One registered round of encryption or decryption with a valid bit.
// ============================================================================
module aes_round
    import aes_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  logic   in_valid,
    input  logic   in_enc,
    input  logic   in_last,
    input  block_t in_state,
    input  block_t key_enc,
    input  block_t key_dec,
    output logic   out_valid,
    output logic   out_enc,
    output block_t out_state
);

    block_t enc_mid;
    block_t dec_mid;
    block_t state_next;
    logic   valid_reg;
    logic   enc_reg;
    block_t state_reg;

    // Encrypt: SubBytes, ShiftRows, MixColumns (skipped last), AddRoundKey.
    // Decrypt: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns (skipped
    // last), which is the textbook inverse order regrouped per round.
    always_comb begin
        enc_mid = shift_rows_fwd(sub_bytes_fwd(in_state));
        if (!in_last) begin
            enc_mid = mix_fwd(enc_mid);
        end
        enc_mid = enc_mid ^ key_enc;
        dec_mid = sub_bytes_inv(shift_rows_inv(in_state)) ^ key_dec;
        if (!in_last) begin
            dec_mid = mix_inv(dec_mid);
        end
        state_next = in_enc ? enc_mid : dec_mid;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            enc_reg   <= in_enc;
            state_reg <= state_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_enc   = enc_reg;
    assign out_state = state_reg;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Drives encrypt and decrypt items under several keys, predicts each result
// with an independent AES-128 model and checks every output item in order.
// ----------------------------------------------------------------------------
module testbench;
    import aes_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KindDecrypt = 1'b0;
    localparam logic KindEncrypt = 1'b1;

    // The key schedule registers settle down their chain after a key write, and
    // the pipeline itself is 11 stages deep.
    localparam int SettleCycles = 16;

    // Independent AES-128 model over byte arrays, bytes taken column-major
    // from the most significant byte of the 128-bit block.
    class cipher_scoreboard;
        logic [127:0] key;
        logic [127:0] pending_blocks[$];
        int           fail_count;

        function logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
            logic [8:0] x;
            logic [7:0] acc;
            x = {1'b0, a};
            acc = 8'h00;
            for (int i = 0; i < 8; i++)
            begin
                if (b[i])
                    acc ^= x[7:0];
                x = x << 1;
                if (x[8])
                    x ^= 9'h11b;
            end
            return acc;
        endfunction

        // The forward S-box is built as the multiplicative inverse followed
        // by the affine map, so no table is shared with the design.
        function logic [7:0] sbox(logic [7:0] a);
            logic [7:0] inv;
            logic [7:0] r;
            inv = 8'h00;
            for (int i = 1; i < 256; i++)
                if (gmul(a, 8'(i)) == 8'h01)
                    inv = 8'(i);
            for (int i = 0; i < 8; i++)
                r[i] = inv[i] ^ inv[(i + 4) % 8] ^ inv[(i + 5) % 8] ^
                       inv[(i + 6) % 8] ^ inv[(i + 7) % 8];
            return r ^ 8'h63;
        endfunction

        logic [7:0] fwd_tab[256];
        logic [7:0] inv_tab[256];

        function void build_tables();
            for (int i = 0; i < 256; i++)
            begin
                fwd_tab[i] = sbox(8'(i));
                inv_tab[fwd_tab[i]] = 8'(i);
            end
        endfunction

        function logic [127:0] encipher(logic enc, logic [127:0] blk);
            logic [7:0] rk[11][16];
            logic [7:0] s[16];
            logic [7:0] t[16];
            logic [7:0] rcon;
            logic [7:0] c0, c1, c2, c3;
            logic [127:0] res;
            rcon = 8'h01;
            for (int i = 0; i < 16; i++)
            begin
                rk[0][i] = key[127 - 8*i -: 8];
                s[i] = blk[127 - 8*i -: 8];
            end
            for (int r = 1; r < 11; r++)
            begin
                rk[r][0] = rk[r-1][0] ^ fwd_tab[rk[r-1][13]] ^ rcon;
                rk[r][1] = rk[r-1][1] ^ fwd_tab[rk[r-1][14]];
                rk[r][2] = rk[r-1][2] ^ fwd_tab[rk[r-1][15]];
                rk[r][3] = rk[r-1][3] ^ fwd_tab[rk[r-1][12]];
                for (int j = 4; j < 16; j++)
                    rk[r][j] = rk[r][j-4] ^ rk[r-1][j];
                rcon = gmul(rcon, 8'h02);
            end
            if (enc)
            begin
                for (int i = 0; i < 16; i++)
                    s[i] ^= rk[0][i];
                for (int r = 1; r < 11; r++)
                begin
                    // Row r shifts left by r: new byte i takes old byte i+4r.
                    for (int i = 0; i < 16; i++)
                        t[i] = fwd_tab[s[(i + 4*(i % 4)) % 16]];
                    for (int c = 0; c < 4; c++)
                    begin
                        c0 = t[4*c]; c1 = t[4*c+1]; c2 = t[4*c+2]; c3 = t[4*c+3];
                        if (r < 10)
                        begin
                            t[4*c]   = gmul(c0,2) ^ gmul(c1,3) ^ c2 ^ c3;
                            t[4*c+1] = c0 ^ gmul(c1,2) ^ gmul(c2,3) ^ c3;
                            t[4*c+2] = c0 ^ c1 ^ gmul(c2,2) ^ gmul(c3,3);
                            t[4*c+3] = gmul(c0,3) ^ c1 ^ c2 ^ gmul(c3,2);
                        end
                    end
                    for (int i = 0; i < 16; i++)
                        s[i] = t[i] ^ rk[r][i];
                end
            end
            else
            begin
                for (int r = 10; r >= 1; r--)
                begin
                    for (int i = 0; i < 16; i++)
                        t[i] = s[i] ^ rk[r][i];
                    if (r < 10)
                    begin
                        for (int c = 0; c < 4; c++)
                        begin
                            c0 = t[4*c]; c1 = t[4*c+1]; c2 = t[4*c+2]; c3 = t[4*c+3];
                            t[4*c]   = gmul(c0,14) ^ gmul(c1,11) ^ gmul(c2,13) ^ gmul(c3,9);
                            t[4*c+1] = gmul(c0,9) ^ gmul(c1,14) ^ gmul(c2,11) ^ gmul(c3,13);
                            t[4*c+2] = gmul(c0,13) ^ gmul(c1,9) ^ gmul(c2,14) ^ gmul(c3,11);
                            t[4*c+3] = gmul(c0,11) ^ gmul(c1,13) ^ gmul(c2,9) ^ gmul(c3,14);
                        end
                    end
                    for (int i = 0; i < 16; i++)
                        s[i] = inv_tab[t[(i + 16 - 4*(i % 4)) % 16]];
                end
                for (int i = 0; i < 16; i++)
                    s[i] ^= rk[0][i];
            end
            for (int i = 0; i < 16; i++)
                res[127 - 8*i -: 8] = s[i];
            return res;
        endfunction

        function void note_input(logic k, logic [63:0] hi, logic [63:0] lo);
            pending_blocks.push_back(encipher(k, {hi, lo}));
        endfunction

        function void check_result(logic [63:0] hi, logic [63:0] lo);
            logic [127:0] want;
            if (pending_blocks.size() == 0)
            begin
                $display("%t: unexpected item: expected none, actual %h %h", $realtime, hi, lo);
                fail_count++;
                return;
            end
            want = pending_blocks.pop_front();
            if (want[127:64] !== hi)
            begin
                $display("%t: out_high mismatch: expected %h, actual %h",
                         $realtime, want[127:64], hi);
                fail_count++;
            end
            if (want[63:0] !== lo)
            begin
                $display("%t: out_low mismatch: expected %h, actual %h",
                         $realtime, want[63:0], lo);
                fail_count++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [63:0] text_high;
    logic [63:0] text_low;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    cipher_scoreboard blocks_sb;
    // The receiver is held off while this is set, and the long stall is
    // counted inside the receiver process itself.
    bit long_stall_req;
    bit stim_done;

    aes128_block_cipher u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .text_high (text_high),
        .text_low  (text_low),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_high  (out_high),
        .out_low   (out_low),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Writes one key register, then lets the round keys settle. Both the
    // model and the design take the write only once it is handshaken.
    task automatic write_key(logic [1:0] idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CfgKeyHigh)
            blocks_sb.key[127:64] = value;
        else if (idx == CfgKeyLow)
            blocks_sb.key[63:0] = value;
        cfg_valid <= 1'b0;
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Offers one item after a random gap, or none when no_gap is set, and
    // waits for it to be accepted. Valid is dropped only when a gap follows or
    // the sender drains, so back-to-back items keep it high.
    task automatic send_block(logic k, logic [63:0] hi, logic [63:0] lo, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        text_high <= hi;
        text_low  <= lo;
        do
            @(posedge clk);
        while (!in_ready);
        blocks_sb.note_input(k, hi, lo);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (blocks_sb.pending_blocks.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Receiver: draws a stall length per item; a requested long stall holds
    // ready low while the sender keeps offering.
    initial
    begin
        int wait_cycles;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_stall_req)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_stall_req = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (wait_cycles != 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            blocks_sb.check_result(out_high, out_low);
        end
    end

    initial
    begin
        #20ms;
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        logic [63:0] keys_hi[4];
        logic [63:0] keys_lo[4];
        bit burst;
        blocks_sb = new();
        blocks_sb.build_tables();
        blocks_sb.key = '0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        kind      <= KindDecrypt;
        text_high <= '0;
        text_low  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CfgKeyHigh;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SettleCycles) @(posedge clk);

        // Directed: the reset key of all zeros, then the standard example key
        // with all-zero and all-one blocks in both directions, then an all-ones key.
        send_block(KindEncrypt, '0, '0, 1'b0);
        send_block(KindDecrypt, '1, '1, 1'b0);
        drain();
        write_key(CfgKeyHigh, 64'h2b7e151628aed2a6);
        write_key(CfgKeyLow,  64'habf7158809cf4f3c);
        send_block(KindEncrypt, 64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b0);
        send_block(KindDecrypt, 64'h3925841d02dc09fb, 64'hdc118597196a0b32, 1'b0);
        send_block(KindEncrypt, '0, '0, 1'b0);
        send_block(KindEncrypt, '1, '1, 1'b0);
        send_block(KindDecrypt, '0, '0, 1'b0);
        send_block(KindDecrypt, '1, '1, 1'b0);
        send_block(KindEncrypt, 64'h8000000000000000, 64'h0000000000000001, 1'b0);
        drain();
        write_key(CfgKeyHigh, '1);
        write_key(CfgKeyLow,  '1);
        send_block(KindEncrypt, '0, '1, 1'b0);
        send_block(KindDecrypt, '1, '0, 1'b0);
        drain();

        keys_hi = '{64'h0, 64'hffffffffffffffff, 64'h000102030405060f, 64'h0};
        keys_lo = '{64'h0, 64'h0, 64'h08090a0b0c0d0e0f, 64'h0};
        keys_hi[3] = rand64();
        keys_lo[3] = rand64();

        // Random phases, each under its own key, with the long receiver
        // stall in one phase and a full drain before every key change.
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph < 4)
            begin
                write_key(CfgKeyHigh, keys_hi[ph]);
                write_key(CfgKeyLow, keys_lo[ph]);
            end
            else
            begin
                write_key(CfgKeyHigh, rand64());
                write_key(CfgKeyLow, rand64());
            end
            if (ph == 2)
                long_stall_req = 1'b1;
            for (int n = 0; n < 190; n++)
            begin
                burst = (ph == 2) || ((n / 30) % 2 == 1);
                send_block(1'($urandom()), rand64(), rand64(), burst);
            end
            drain();
        end
        stim_done = 1'b1;

        drain();
        if (blocks_sb.fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
